### rtl/order_book_level_table_top_defines.svh
// Assertion macros for the order book level table RTL.
`ifndef ORDER_BOOK_LEVEL_TABLE_TOP_DEFINES_SVH
`define ORDER_BOOK_LEVEL_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define OBL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("order book level table check failed");

// Next-cycle implication, off during reset.
`define OBL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("order book level table check failed");

`endif

### rtl/obl_pkg.sv
`default_nettype none

package obl_pkg;

   localparam int LEVELS     = 256;
   localparam int PRICE_W    = 32;
   localparam int QTY_W      = 48;
   localparam int COUNT_W    = $clog2(LEVELS + 1);
   localparam int GROUP_SIZE = 16;
   localparam int NUM_GROUPS = (LEVELS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GROUP_PAD  = NUM_GROUPS * GROUP_SIZE;

   typedef struct packed {
      logic insert;
      logic remove;
      logic overwrite;
   } obl_op_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CMP    = 5'b00010,
      ST_REDUCE = 5'b00100,
      ST_APPLY  = 5'b01000,
      ST_REPORT = 5'b10000
   } obl_state_type;

endpackage

`default_nettype wire

### rtl/order_book_level_table_top.sv
// The result strobe rises once an accepted item has passed the compare, reduce and apply states.
// No new item is taken while one is in those states; the next item is taken in the strobe cycle.
// The cell row sets the pace: compare, registered match reduction, then shift.
// Reset clears both level counts and the control state; table entries stay unwritten.
// The receiver cannot stall: each result shows for one cycle only.
`default_nettype none
`include "order_book_level_table_top_defines.svh"

module order_book_level_table_top import obl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_side,
   input  logic [PRICE_W-1:0] req_price,
   input  logic [QTY_W-1:0]   req_quantity,
   input  logic               req_is_snapshot,
   output logic               rsp_valid,
   output logic [PRICE_W-1:0] rsp_best_bid_price,
   output logic [QTY_W-1:0]   rsp_best_bid_quantity,
   output logic [PRICE_W-1:0] rsp_best_ask_price,
   output logic [QTY_W-1:0]   rsp_best_ask_quantity,
   output logic [COUNT_W-1:0] rsp_bid_levels,
   output logic [COUNT_W-1:0] rsp_ask_levels,
   output logic               rsp_bid_present,
   output logic               rsp_ask_present,
   output logic               rsp_table_full
);

   obl_state_type      state_ff;
   obl_state_type      state_in;
   logic               side_ff;
   logic               remove_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   qty_ff;
   logic               accept;
   logic               apply;
   logic [COUNT_W-1:0] bid_count;
   logic [COUNT_W-1:0] ask_count;
   logic [PRICE_W-1:0] bid_price;
   logic [QTY_W-1:0]   bid_qty;
   logic [PRICE_W-1:0] ask_price;
   logic [QTY_W-1:0]   ask_qty;
   logic               bid_dropped;
   logic               ask_dropped;

   assign busy   = !(state_ff == ST_IDLE || state_ff == ST_REPORT);
   assign accept = start && !busy;
   assign apply  = (state_ff == ST_APPLY);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_CMP;
         ST_CMP:    state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_APPLY;
         ST_APPLY:  state_in = ST_REPORT;
         ST_REPORT: state_in = accept ? ST_CMP : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the item for the whole pass through the cell row
   always_ff @(posedge clock) begin
      if (accept) begin
         side_ff   <= req_side;
         price_ff  <= req_price;
         qty_ff    <= req_quantity;
         remove_ff <= !req_is_snapshot && (req_quantity == '0);
      end
   end

   obl_side u_bid (
      .clock      (clock),
      .reset      (reset),
      .descending (1'b1),
      .apply      (apply),
      .selected   (!side_ff),
      .remove     (remove_ff),
      .item_price (price_ff),
      .item_qty   (qty_ff),
      .count      (bid_count),
      .best_price (bid_price),
      .best_qty   (bid_qty),
      .dropped    (bid_dropped)
   );

   obl_side u_ask (
      .clock      (clock),
      .reset      (reset),
      .descending (1'b0),
      .apply      (apply),
      .selected   (side_ff),
      .remove     (remove_ff),
      .item_price (price_ff),
      .item_qty   (qty_ff),
      .count      (ask_count),
      .best_price (ask_price),
      .best_qty   (ask_qty),
      .dropped    (ask_dropped)
   );

   always_comb begin
      rsp_valid             = (state_ff == ST_REPORT);
      rsp_bid_present       = (bid_count != '0);
      rsp_ask_present       = (ask_count != '0);
      rsp_best_bid_price    = rsp_bid_present ? bid_price : '0;
      rsp_best_bid_quantity = rsp_bid_present ? bid_qty : '0;
      rsp_best_ask_price    = rsp_ask_present ? ask_price : '0;
      rsp_best_ask_quantity = rsp_ask_present ? ask_qty : '0;
      rsp_bid_levels        = bid_count;
      rsp_ask_levels        = ask_count;
      rsp_table_full        = bid_dropped || ask_dropped;
   end

   `OBL_ASSERT_NEXT(a_accept_starts_work, clock, reset, accept, busy && !rsp_valid)
   `OBL_ASSERT_NEXT(a_apply_then_report, clock, reset, apply, rsp_valid)
   `OBL_ASSERT_IMPLY(a_drop_keeps_counts, clock, reset, rsp_valid && rsp_table_full,
      $stable(rsp_bid_levels) && $stable(rsp_ask_levels))
   `OBL_ASSERT_IMPLY(a_drop_only_when_full, clock, reset, rsp_valid && rsp_table_full,
      bid_count == COUNT_W'(LEVELS) || ask_count == COUNT_W'(LEVELS))
   `OBL_ASSERT_IMPLY(a_count_in_range, clock, reset, 1'b1,
      bid_count <= COUNT_W'(LEVELS) && ask_count <= COUNT_W'(LEVELS))

endmodule

`default_nettype wire

### rtl/obl_cell.sv
`default_nettype none

module obl_cell import obl_pkg::*; (
   input  logic               clock,
   input  logic               valid,
   input  logic               descending,
   input  logic [PRICE_W-1:0] item_price,
   input  logic [QTY_W-1:0]   item_qty,
   input  logic               left_before,
   input  logic [PRICE_W-1:0] left_price,
   input  logic [QTY_W-1:0]   left_qty,
   input  logic [PRICE_W-1:0] right_price,
   input  logic [QTY_W-1:0]   right_qty,
   input  obl_op_type         op,
   output logic               ahead,
   output logic               equal,
   output logic [PRICE_W-1:0] price,
   output logic [QTY_W-1:0]   qty
);

   logic               before_ff;
   logic               before_in;
   logic               equal_ff;
   logic               equal_in;
   logic [PRICE_W-1:0] price_ff;
   logic [PRICE_W-1:0] price_in;
   logic [QTY_W-1:0]   qty_ff;
   logic [QTY_W-1:0]   qty_in;

   always_comb begin
      before_in = valid && (descending ? (price_ff > item_price) : (price_ff < item_price));
      equal_in  = valid && (price_ff == item_price);
   end

   always_comb begin
      price_in = price_ff;
      qty_in   = qty_ff;
      if (op.insert && !before_ff) begin
         if (left_before) begin
            price_in = item_price;
            qty_in   = item_qty;
         end else begin
            price_in = left_price;
            qty_in   = left_qty;
         end
      end else if (op.remove && !before_ff) begin
         price_in = right_price;
         qty_in   = right_qty;
      end else if (op.overwrite && equal_ff) begin
         qty_in = item_qty;
      end
   end

   always_ff @(posedge clock) begin
      before_ff <= before_in;
      equal_ff  <= equal_in;
      price_ff  <= price_in;
      qty_ff    <= qty_in;
   end

   assign ahead = before_ff;
   assign equal = equal_ff;
   assign price = price_ff;
   assign qty   = qty_ff;

endmodule

`default_nettype wire

### rtl/obl_side.sv
`default_nettype none

module obl_side import obl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               descending,
   input  logic               apply,
   input  logic               selected,
   input  logic               remove,
   input  logic [PRICE_W-1:0] item_price,
   input  logic [QTY_W-1:0]   item_qty,
   output logic [COUNT_W-1:0] count,
   output logic [PRICE_W-1:0] best_price,
   output logic [QTY_W-1:0]   best_qty,
   output logic               dropped
);

   logic [PRICE_W-1:0]    price_arr [LEVELS];
   logic [QTY_W-1:0]      qty_arr   [LEVELS];
   logic [LEVELS-1:0]     before_vec;
   logic [LEVELS-1:0]     equal_vec;
   logic [GROUP_PAD-1:0]  equal_pad;
   logic [NUM_GROUPS-1:0] group_ff;
   logic [NUM_GROUPS-1:0] group_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic                  dropped_ff;
   logic                  dropped_in;
   logic                  match;
   logic                  full;
   logic                  active;
   obl_op_type            op;

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      logic               left_before;
      logic [PRICE_W-1:0] left_price;
      logic [QTY_W-1:0]   left_qty;
      logic [PRICE_W-1:0] right_price;
      logic [QTY_W-1:0]   right_qty;

      if (i == 0) begin : g_first
         assign left_before = 1'b1;
         assign left_price  = item_price;
         assign left_qty    = item_qty;
      end else begin : g_inner
         assign left_before = before_vec[i-1];
         assign left_price  = price_arr[i-1];
         assign left_qty    = qty_arr[i-1];
      end

      if (i == LEVELS - 1) begin : g_last
         assign right_price = price_arr[i];
         assign right_qty   = qty_arr[i];
      end else begin : g_next
         assign right_price = price_arr[i+1];
         assign right_qty   = qty_arr[i+1];
      end

      obl_cell u_cell (
         .clock       (clock),
         .valid       (count_ff > COUNT_W'(i)),
         .descending  (descending),
         .item_price  (item_price),
         .item_qty    (item_qty),
         .left_before (left_before),
         .left_price  (left_price),
         .left_qty    (left_qty),
         .right_price (right_price),
         .right_qty   (right_qty),
         .op          (op),
         .ahead       (before_vec[i]),
         .equal       (equal_vec[i]),
         .price       (price_arr[i]),
         .qty         (qty_arr[i])
      );
   end

   always_comb begin
      equal_pad = '0;
      equal_pad[LEVELS-1:0] = equal_vec;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = |equal_pad[g*GROUP_SIZE +: GROUP_SIZE];
      end
   end

   always_comb begin
      match        = |group_ff;
      full         = (count_ff == COUNT_W'(LEVELS));
      active       = apply && selected;
      op.insert    = active && !match && !remove && !full;
      op.remove    = active && match && remove;
      op.overwrite = active && match && !remove;
      count_in     = count_ff;
      if (op.insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (op.remove) begin
         count_in = count_ff - COUNT_W'(1);
      end
      dropped_in = dropped_ff;
      if (apply) begin
         dropped_in = active && !match && !remove && full;
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign count      = count_ff;
   assign best_price = price_arr[0];
   assign best_qty   = qty_arr[0];
   assign dropped    = dropped_ff;

endmodule

`default_nettype wire

### test/tb_order_book_level_table_top.sv
`timescale 1ns / 1ps

module tb_order_book_level_table_top import obl_pkg::*; ();

   typedef enum logic {
      SIDE_BID   = 1'b0,
      SIDE_OFFER = 1'b1
   } book_side_type;

   typedef enum logic {
      KIND_UPDATE   = 1'b0,
      KIND_SNAPSHOT = 1'b1
   } change_kind_type;

   typedef struct {
      book_side_type      side;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      change_kind_type    kind;
      int                 idle_pct;
      bit                 wait_drain;
   } level_change_type;

   typedef struct {
      logic [PRICE_W-1:0] bid_px;
      logic [QTY_W-1:0]   bid_qty;
      logic [PRICE_W-1:0] ask_px;
      logic [QTY_W-1:0]   ask_qty;
      logic [COUNT_W-1:0] bid_n;
      logic [COUNT_W-1:0] ask_n;
      logic               bid_on;
      logic               ask_on;
      logic               full;
   } book_top_type;

   localparam logic [PRICE_W-1:0] PX_MAX  = {PRICE_W{1'b1}};
   localparam logic [QTY_W-1:0]   QTY_MAX = {QTY_W{1'b1}};
   localparam int FILL_N      = LEVELS + 4;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock;
   logic               reset;
   logic               start           = 1'b0;
   logic               busy;
   logic               req_side        = 1'b0;
   logic [PRICE_W-1:0] req_price       = '0;
   logic [QTY_W-1:0]   req_quantity    = '0;
   logic               req_is_snapshot = 1'b0;
   logic               rsp_valid;
   logic [PRICE_W-1:0] rsp_best_bid_price;
   logic [QTY_W-1:0]   rsp_best_bid_quantity;
   logic [PRICE_W-1:0] rsp_best_ask_price;
   logic [QTY_W-1:0]   rsp_best_ask_quantity;
   logic [COUNT_W-1:0] rsp_bid_levels;
   logic [COUNT_W-1:0] rsp_ask_levels;
   logic               rsp_bid_present;
   logic               rsp_ask_present;
   logic               rsp_table_full;

   level_change_type pending_changes[$];
   book_top_type     expected_tops[$];
   int               n_taken = 0;
   int               n_seen  = 0;
   int               errors  = 0;
   int               cycles  = 0;
   bit               hold_next = 1'b0;

   logic [PRICE_W-1:0] lvl_px[2][LEVELS];
   logic [QTY_W-1:0]   lvl_qty[2][LEVELS];
   int                 lvl_n[2] = '{0, 0};
   logic [PRICE_W-1:0] px_pool[16];

   order_book_level_table_top u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_side              (req_side),
      .req_price             (req_price),
      .req_quantity          (req_quantity),
      .req_is_snapshot       (req_is_snapshot),
      .rsp_valid             (rsp_valid),
      .rsp_best_bid_price    (rsp_best_bid_price),
      .rsp_best_bid_quantity (rsp_best_bid_quantity),
      .rsp_best_ask_price    (rsp_best_ask_price),
      .rsp_best_ask_quantity (rsp_best_ask_quantity),
      .rsp_bid_levels        (rsp_bid_levels),
      .rsp_ask_levels        (rsp_ask_levels),
      .rsp_bid_present       (rsp_bid_present),
      .rsp_ask_present       (rsp_ask_present),
      .rsp_table_full        (rsp_table_full)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Apply one level change to the shadow book; flag a drop on a full side.
   task automatic apply_level_change(input level_change_type c, output logic dropped);
      int  s;
      int  n;
      int  pos;
      int  i;
      bit  ahead;
      bit  remove;
      s = int'(c.side);
      n = lvl_n[s];
      pos = 0;
      remove = (c.kind == KIND_UPDATE) && (c.qty == '0);
      dropped = 1'b0;
      while (pos < n) begin
         ahead = (c.side == SIDE_BID) ? (lvl_px[s][pos] > c.price)
                                      : (lvl_px[s][pos] < c.price);
         if (!ahead)
            break;
         pos++;
      end
      if (pos < n && lvl_px[s][pos] == c.price) begin
         if (remove) begin
            for (i = pos; i < n - 1; i++) begin
               lvl_px[s][i]  = lvl_px[s][i + 1];
               lvl_qty[s][i] = lvl_qty[s][i + 1];
            end
            lvl_n[s] = n - 1;
         end else begin
            lvl_qty[s][pos] = c.qty;
         end
      end else if (!remove) begin
         if (n >= LEVELS) begin
            dropped = 1'b1;
         end else begin
            for (i = n; i > pos; i--) begin
               lvl_px[s][i]  = lvl_px[s][i - 1];
               lvl_qty[s][i] = lvl_qty[s][i - 1];
            end
            lvl_px[s][pos]  = c.price;
            lvl_qty[s][pos] = c.qty;
            lvl_n[s] = n + 1;
         end
      end
   endtask

   function automatic book_top_type book_top(input logic dropped);
      book_top_type t;
      t.bid_on  = (lvl_n[0] != 0);
      t.ask_on  = (lvl_n[1] != 0);
      t.bid_px  = t.bid_on ? lvl_px[0][0] : '0;
      t.bid_qty = t.bid_on ? lvl_qty[0][0] : '0;
      t.ask_px  = t.ask_on ? lvl_px[1][0] : '0;
      t.ask_qty = t.ask_on ? lvl_qty[1][0] : '0;
      t.bid_n   = COUNT_W'(lvl_n[0]);
      t.ask_n   = COUNT_W'(lvl_n[1]);
      t.full    = dropped;
      return t;
   endfunction

   // Driver: present the next item once the previous one is taken.
   always @(posedge clock) begin : drive
      level_change_type cur;
      level_change_type nxt;
      logic             dropped;
      int               took;
      bit               offer;
      took = (start && !busy) ? 1 : 0;
      if (took == 1) begin
         apply_level_change(cur, dropped);
         expected_tops.push_back(book_top(dropped));
      end
      offer = start && (took == 0);
      if (!offer && !reset && pending_changes.size() > 0) begin
         nxt = pending_changes[0];
         if ((!nxt.wait_drain || n_taken + took == n_seen) &&
             $urandom_range(99) >= nxt.idle_pct) begin
            void'(pending_changes.pop_front());
            cur = nxt;
            offer = 1'b1;
            req_side        <= cur.side;
            req_price       <= cur.price;
            req_quantity    <= cur.qty;
            req_is_snapshot <= cur.kind;
         end
      end
      start   <= offer;
      n_taken <= n_taken + took;
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Monitor: match every strobe against the oldest expectation.
   always @(posedge clock) begin : watch
      book_top_type e;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_tops.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none, actual bid %0h ask %0h",
                     $time, rsp_best_bid_price, rsp_best_ask_price);
         end else begin
            e = expected_tops.pop_front();
            check_field("best_bid_price", 64'(e.bid_px), 64'(rsp_best_bid_price));
            check_field("best_bid_quantity", 64'(e.bid_qty), 64'(rsp_best_bid_quantity));
            check_field("best_ask_price", 64'(e.ask_px), 64'(rsp_best_ask_price));
            check_field("best_ask_quantity", 64'(e.ask_qty), 64'(rsp_best_ask_quantity));
            check_field("bid_levels", 64'(e.bid_n), 64'(rsp_bid_levels));
            check_field("ask_levels", 64'(e.ask_n), 64'(rsp_ask_levels));
            check_field("bid_present", 64'(e.bid_on), 64'(rsp_bid_present));
            check_field("ask_present", 64'(e.ask_on), 64'(rsp_ask_present));
            check_field("table_full", 64'(e.full), 64'(rsp_table_full));
            n_seen <= n_seen + 1;
         end
      end
   end

   task automatic add_change(input book_side_type side, input logic [PRICE_W-1:0] price,
                             input logic [QTY_W-1:0] qty, input change_kind_type kind);
      level_change_type c;
      int idx;
      idx = pending_changes.size();
      c.side = side;
      c.price = price;
      c.qty = qty;
      c.kind = kind;
      c.idle_pct = (idx < 590) ? 23 : (idx < 1180) ? 46 : 0;
      c.wait_drain = hold_next;
      hold_next = 1'b0;
      pending_changes.push_back(c);
   endtask

   function automatic logic [QTY_W-1:0] rand_qty();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(9))
         0, 1:    return '0;
         2:       return QTY_MAX;
         3:       return QTY_W'(r[7:0]);
         default: return r[QTY_W-1:0];
      endcase
   endfunction

   function automatic book_side_type rand_side();
      return ($urandom_range(1) == 1) ? SIDE_OFFER : SIDE_BID;
   endfunction

   function automatic change_kind_type rand_kind();
      return ($urandom_range(3) == 0) ? KIND_SNAPSHOT : KIND_UPDATE;
   endfunction

   task automatic add_random(input int count);
      logic [PRICE_W-1:0] p;
      for (int i = 0; i < count; i++) begin
         p = ($urandom_range(9) < 7) ? px_pool[$urandom_range(15)] : $urandom;
         add_change(rand_side(), p, rand_qty(), rand_kind());
      end
   endtask

   // Fill one side past capacity, hit it while full, then remove every price of the fill.
   task automatic fill_side(input book_side_type side);
      logic [PRICE_W-1:0] fresh[FILL_N];
      logic [QTY_W-1:0]   q;
      change_kind_type    k;
      hold_next = 1'b1;
      for (int i = 0; i < FILL_N; i++) begin
         fresh[i] = $urandom;
         k = rand_kind();
         q = rand_qty();
         if (k == KIND_UPDATE && q == '0)
            q = QTY_W'(1);
         add_change(side, fresh[i], q, k);
      end
      add_change(side, $urandom, QTY_MAX, KIND_UPDATE);
      add_change(side, fresh[3], QTY_W'(77), KIND_UPDATE);
      add_change(side, fresh[4], '0, KIND_SNAPSHOT);
      add_change(side, fresh[5], '0, KIND_UPDATE);
      add_change(side, $urandom, QTY_W'(9), KIND_SNAPSHOT);
      add_change(side, $urandom, QTY_W'(9), KIND_SNAPSHOT);
      for (int i = 0; i < 20; i++) begin
         if ($urandom_range(1) == 1)
            add_change(side, $urandom, rand_qty(), KIND_SNAPSHOT);
         else
            add_change(side, fresh[6 + $urandom_range(90)], rand_qty(), rand_kind());
      end
      for (int i = 0; i < FILL_N; i++)
         add_change(side, fresh[(i * 97) % FILL_N], '0, KIND_UPDATE);
   endtask

   initial begin
      for (int i = 0; i < 16; i++)
         px_pool[i] = $urandom;
      px_pool[0] = '0;
      px_pool[1] = PX_MAX;
      px_pool[2] = PRICE_W'(1);

      add_change(SIDE_BID, PRICE_W'(100), '0, KIND_UPDATE);
      add_change(SIDE_OFFER, PRICE_W'(100), '0, KIND_UPDATE);
      add_change(SIDE_BID, PX_MAX, QTY_MAX, KIND_UPDATE);
      add_change(SIDE_OFFER, '0, QTY_W'(1), KIND_UPDATE);
      add_change(SIDE_BID, '0, '0, KIND_SNAPSHOT);
      add_change(SIDE_OFFER, PX_MAX, '0, KIND_SNAPSHOT);
      add_change(SIDE_BID, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, KIND_UPDATE);
      add_change(SIDE_OFFER, 32'hAAAA_AAAA, 48'h5555_5555_5555, KIND_SNAPSHOT);
      add_change(SIDE_BID, PX_MAX, QTY_W'(5), KIND_UPDATE);
      add_change(SIDE_OFFER, '0, '0, KIND_SNAPSHOT);
      add_change(SIDE_BID, 32'h5555_5555, '0, KIND_SNAPSHOT);
      add_change(SIDE_BID, PX_MAX, '0, KIND_UPDATE);
      add_change(SIDE_BID, PRICE_W'(12345), '0, KIND_UPDATE);
      add_change(SIDE_BID, 32'h5555_5555, '0, KIND_UPDATE);
      add_change(SIDE_BID, '0, '0, KIND_UPDATE);
      add_change(SIDE_OFFER, '0, '0, KIND_UPDATE);
      add_change(SIDE_OFFER, 32'hAAAA_AAAA, '0, KIND_UPDATE);
      hold_next = 1'b1;
      add_change(SIDE_OFFER, PX_MAX, '0, KIND_UPDATE);
      add_change(SIDE_BID, PRICE_W'(1), QTY_MAX, KIND_UPDATE);
      add_change(SIDE_OFFER, PX_MAX - PRICE_W'(1), QTY_W'(1), KIND_UPDATE);
      add_change(SIDE_BID, PRICE_W'(1), '0, KIND_UPDATE);
      add_change(SIDE_OFFER, PX_MAX - PRICE_W'(1), '0, KIND_UPDATE);

      add_random(330);
      fill_side(SIDE_BID);
      add_random(150);
      fill_side(SIDE_OFFER);
      add_random(150);

      @(negedge clock);
      while (pending_changes.size() != 0 || start || n_taken != n_seen)
         @(negedge clock);
      repeat (12) @(negedge clock);
      if (errors == 0 && expected_tops.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
